[rtl/core/fpba_pkg.sv]
// Package for the fit-policy block allocator: field widths, codes, state and
// cell command types. Used by every module under rtl/core; depends on nothing.
`default_nettype none

package fpba_pkg;

    // Default sizes of the table
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed port field widths
    localparam int SLOT_W     = 4;
    localparam int IO_SIZE_W  = 16;
    localparam int STATUS_W   = 2;
    localparam int CHOSEN_W   = 4;
    localparam int POLICY_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // Fit policies; the unused code behaves as first fit
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;

    // Reset value of the block count register
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // Broadcast commands from the controller to every cell
    typedef struct packed {
        logic load;     // write original and remaining size of one slot
        logic wb;       // write back the remaining size of the chosen block
        logic restore;  // copy original sizes into remaining sizes
    } t_cell_cmd;

endpackage

`default_nettype wire

[rtl/core/fit_policy_block_allocator.sv]
// Top level of the fit-policy block allocator: controller, configuration
// registers and the chain of fpba_cell. Depends on fpba_pkg and fpba_cell.
//
//   channel | valid      | ready       | payload
//   --------+------------+-------------+---------------------------------------
//   in      | i_in_valid | o_in_ready  | req_type, block_slot, load_size, ...
//   out     | o_out_valid| i_out_ready | status, chosen_block, remaining_after
//   cfg     | i_cfg_valid| o_cfg_ready | cfg_index, cfg_data
//
// A load item gives its result in the cycle after acceptance. An allocate item
// passes a candidate packet through the MAX_BLOCKS cells, one cell a cycle,
// behind the launch register and ahead of the output register; its result shows
// in the same cycle in which the next item can be taken, so items are not
// overlapped.
// Reset clears control only and holds both ready outputs low; table contents
// are unknown until loaded.
// An item is accepted only when the output register is free or draining.
`default_nettype none

module fit_policy_block_allocator #(
    parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input items
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_req_type,
    input  wire [fpba_pkg::SLOT_W-1:0]        i_block_slot,
    input  wire [fpba_pkg::IO_SIZE_W-1:0]     i_load_size,
    input  wire [fpba_pkg::IO_SIZE_W-1:0]     i_request_size,
    input  wire                               i_last_request,
    // result items
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [fpba_pkg::STATUS_W-1:0]     o_status,
    output logic [fpba_pkg::CHOSEN_W-1:0]     o_chosen_block,
    output logic [fpba_pkg::IO_SIZE_W-1:0]    o_remaining_after,
    // configuration writes
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [fpba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [fpba_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    fpba_pkg::t_state                r_state;
    fpba_pkg::t_state                n_state;
    logic                            r_launch;
    logic [SIZE_BITS-1:0]            r_req;
    logic                            r_last;
    logic [fpba_pkg::POLICY_W-1:0]   r_policy;
    logic [fpba_pkg::COUNT_W-1:0]    r_count;
    logic                            r_out_valid;
    logic [fpba_pkg::STATUS_W-1:0]   r_status;
    logic [fpba_pkg::CHOSEN_W-1:0]   r_chosen;
    logic [fpba_pkg::IO_SIZE_W-1:0]  r_remain;

    fpba_pkg::t_cell_cmd             cmd;
    logic                            in_acc;
    logic                            out_free;
    logic                            scan_done;
    logic [SIZE_BITS-1:0]            left;

    logic                            pk_valid [0:MAX_BLOCKS];
    logic                            pk_found [0:MAX_BLOCKS];
    logic [IDX_W-1:0]                pk_pick  [0:MAX_BLOCKS];
    logic [SIZE_BITS-1:0]            pk_val   [0:MAX_BLOCKS];

    // Handshake
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = i_rst_n && (r_state == fpba_pkg::S_IDLE) && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_status          = r_status;
    assign o_chosen_block    = r_chosen;
    assign o_remaining_after = r_remain;

    // Seed packet enters cell zero
    assign pk_valid[0] = r_launch;
    assign pk_found[0] = 1'b0;
    assign pk_pick[0]  = '0;
    assign pk_val[0]   = '0;

    assign scan_done = pk_valid[MAX_BLOCKS];
    assign left      = pk_val[MAX_BLOCKS] - r_req;

    // Next state and cell commands
    always_comb begin
        n_state     = r_state;
        cmd.load    = 1'b0;
        cmd.wb      = 1'b0;
        cmd.restore = 1'b0;
        case (r_state)
            fpba_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == fpba_pkg::REQ_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        n_state = fpba_pkg::S_SCAN;
                    end
                end
            end
            fpba_pkg::S_SCAN: begin
                if (scan_done) begin
                    cmd.wb      = pk_found[MAX_BLOCKS];
                    cmd.restore = r_last;
                    n_state     = fpba_pkg::S_IDLE;
                end
            end
            default: n_state = fpba_pkg::S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Launch pulse and request hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= 1'b0;
        end else begin
            r_launch <= in_acc && (i_req_type == fpba_pkg::REQ_ALLOC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req  <= SIZE_BITS'(i_request_size);
            r_last <= i_last_request;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= fpba_pkg::POL_FIRST;
            r_count  <= fpba_pkg::COUNT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fpba_pkg::CFG_POLICY: r_policy <= fpba_pkg::POLICY_W'(i_cfg_data);
                fpba_pkg::CFG_COUNT:  r_count  <= fpba_pkg::COUNT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((in_acc && (i_req_type == fpba_pkg::REQ_LOAD)) || scan_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_req_type == fpba_pkg::REQ_LOAD)) begin
            r_status <= fpba_pkg::ST_LOADED;
            r_chosen <= '0;
            r_remain <= '0;
        end else if (scan_done) begin
            if (pk_found[MAX_BLOCKS]) begin
                r_status <= fpba_pkg::ST_ALLOC;
                r_chosen <= fpba_pkg::CHOSEN_W'(pk_pick[MAX_BLOCKS]);
                r_remain <= fpba_pkg::IO_SIZE_W'(left);
            end else begin
                r_status <= fpba_pkg::ST_NO_FIT;
                r_chosen <= '0;
                r_remain <= '0;
            end
        end
    end

    // Chain of cells
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        fpba_cell #(
            .IDX       (g),
            .IDX_W     (IDX_W),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_load_slot (i_block_slot),
            .i_load_val  (SIZE_BITS'(i_load_size)),
            .i_wb_idx    (pk_pick[MAX_BLOCKS]),
            .i_wb_val    (left),
            .i_req       (r_req),
            .i_policy    (r_policy),
            .i_count     (r_count),
            .i_pk_valid  (pk_valid[g]),
            .i_pk_found  (pk_found[g]),
            .i_pk_pick   (pk_pick[g]),
            .i_pk_val    (pk_val[g]),
            .o_pk_valid  (pk_valid[g+1]),
            .o_pk_found  (pk_found[g+1]),
            .o_pk_pick   (pk_pick[g+1]),
            .o_pk_val    (pk_val[g+1])
        );
    end

endmodule

`default_nettype wire

[rtl/core/fpba_cell.sv]
// One table cell: holds the original and remaining size of one block and
// updates the passing best-candidate packet. Depends on fpba_pkg.
`default_nettype none

module fpba_cell #(
    parameter int IDX       = 0,
    parameter int IDX_W     = 4,
    parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // broadcast control and data
    input  wire fpba_pkg::t_cell_cmd         i_cmd,
    input  wire [fpba_pkg::SLOT_W-1:0]       i_load_slot,
    input  wire [SIZE_BITS-1:0]              i_load_val,
    input  wire [IDX_W-1:0]                  i_wb_idx,
    input  wire [SIZE_BITS-1:0]              i_wb_val,
    input  wire [SIZE_BITS-1:0]              i_req,
    input  wire [fpba_pkg::POLICY_W-1:0]     i_policy,
    input  wire [fpba_pkg::COUNT_W-1:0]      i_count,
    // candidate packet from the previous cell
    input  wire                              i_pk_valid,
    input  wire                              i_pk_found,
    input  wire [IDX_W-1:0]                  i_pk_pick,
    input  wire [SIZE_BITS-1:0]              i_pk_val,
    // candidate packet to the next cell
    output logic                             o_pk_valid,
    output logic                             o_pk_found,
    output logic [IDX_W-1:0]                 o_pk_pick,
    output logic [SIZE_BITS-1:0]             o_pk_val
);

    logic [SIZE_BITS-1:0] r_orig;
    logic [SIZE_BITS-1:0] r_rem;
    logic                 in_scan;
    logic                 fits;
    logic                 take;

    // Decide whether this block replaces the candidate
    always_comb begin
        in_scan = 32'(i_count) > IDX;
        fits    = in_scan && (r_rem >= i_req);
        take    = 1'b0;
        if (fits) begin
            if (!i_pk_found) begin
                take = 1'b1;
            end else if (i_policy == fpba_pkg::POL_BEST) begin
                take = r_rem < i_pk_val;
            end else if (i_policy == fpba_pkg::POL_WORST) begin
                take = r_rem > i_pk_val;
            end
        end
    end

    // Advance the packet valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pk_valid <= 1'b0;
        end else begin
            o_pk_valid <= i_pk_valid;
        end
    end

    // Hand the candidate on
    always_ff @(posedge i_clk) begin
        if (take) begin
            o_pk_found <= 1'b1;
            o_pk_pick  <= IDX_W'(IDX);
            o_pk_val   <= r_rem;
        end else begin
            o_pk_found <= i_pk_found;
            o_pk_pick  <= i_pk_pick;
            o_pk_val   <= i_pk_val;
        end
    end

    // Update stored sizes; restore wins over write-back
    always_ff @(posedge i_clk) begin
        if (i_cmd.restore) begin
            r_rem <= r_orig;
        end else if (i_cmd.wb && (i_wb_idx == IDX_W'(IDX))) begin
            r_rem <= i_wb_val;
        end
        if (i_cmd.load && (32'(i_load_slot) == IDX)) begin
            r_orig <= i_load_val;
            r_rem  <= i_load_val;
        end
    end

endmodule

`default_nettype wire

[rtl/core/fpba_checker.sv]
// Port-level checks for the fit-policy block allocator, bound to the top
// level. Depends on fpba_pkg and fit_policy_block_allocator.
`default_nettype none

module fpba_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_valid,
    input wire                              o_in_ready,
    input wire                              i_req_type,
    input wire                              o_out_valid,
    input wire                              i_out_ready,
    input wire [fpba_pkg::STATUS_W-1:0]     o_status,
    input wire [fpba_pkg::CHOSEN_W-1:0]     o_chosen_block,
    input wire [fpba_pkg::IO_SIZE_W-1:0]    o_remaining_after
);

    // Hold a waiting result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_chosen_block) && $stable(o_remaining_after))
        else $error("result changed while stalled");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == fpba_pkg::ST_LOADED)
            || (o_status == fpba_pkg::ST_ALLOC) || (o_status == fpba_pkg::ST_NO_FIT))
        else $error("undefined status");

    // Results without an allocation carry zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != fpba_pkg::ST_ALLOC)
            |-> (o_chosen_block == '0) && (o_remaining_after == '0))
        else $error("nonzero fields without allocation");

    // An allocate item blocks the input at the start of its scan
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_req_type == fpba_pkg::REQ_ALLOC)
            |=> !o_in_ready ##1 !o_in_ready)
        else $error("input taken during scan");

    // A load item gives its result in the next cycle
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_req_type == fpba_pkg::REQ_LOAD)
            |=> o_out_valid && (o_status == fpba_pkg::ST_LOADED))
        else $error("load result missing");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .i_req_type        (i_req_type),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_chosen_block    (o_chosen_block),
    .o_remaining_after (o_remaining_after)
);

`default_nettype wire
